// ----- hw/rtl/world_to_screen_projection_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the projection unit
// Shared assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_UNIT_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define WSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/wsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Projection unit package
// Payload types, register indexes and shared constants.
// ----------------------------------------------------------------------------
package wsp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 64;
	localparam int SCR_W         = 14;
	localparam int DIV_W         = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_XY   = 3'd0,
		REG_X_ZT   = 3'd1,
		REG_Y_XY   = 3'd2,
		REG_Y_ZT   = 3'd3,
		REG_W_XY   = 3'd4,
		REG_W_ZT   = 3'd5,
		REG_SCR_W  = 3'd6,
		REG_SCR_H  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} wsp_in_t;

	typedef struct packed {
		logic               visible;
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
	} wsp_out_t;

	// Matrix row: three weights and a translation.
	typedef struct packed {
		logic signed [31:0] wx;
		logic signed [31:0] wy;
		logic signed [31:0] wz;
		logic signed [31:0] wt;
	} wsp_row_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

// ----- hw/rtl/wsp_divider.sv -----
// ----------------------------------------------------------------------------
// Pipelined fixed-point divider
// Restoring radix-2 division, one quotient bit per stage, with sign handling.
// ----------------------------------------------------------------------------
module wsp_divider
	import wsp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int TAG_W     = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [31:0]  num,
	input  logic [30:0]         den,
	input  logic [TAG_W-1:0]    tag_in,
	output logic                out_valid,
	output logic signed [31:0]  quo,
	output logic [TAG_W-1:0]    tag_out
);
	// Dividend magnitude is at most 2^31, shifted by FRAC_BITS.
	localparam int NW = 32 + FRAC_BITS;
	localparam int ST = NW;

	logic [NW-1:0]      dvd_s   [ST+1];
	logic [31:0]        rem_s   [ST+1];
	logic [NW-1:0]      q_s     [ST+1];
	logic [30:0]        den_s   [ST+1];
	logic               neg_s   [ST+1];
	logic               vld_s   [ST+1];
	logic [TAG_W-1:0]   tag_s   [ST+1];
	logic [31:0]        mag;

	always_comb begin
		mag = num[31] ? 32'(-num) : 32'(num);
	end

	assign dvd_s[0] = {mag, {FRAC_BITS{1'b0}}};
	assign rem_s[0] = '0;
	assign q_s[0]   = '0;
	assign den_s[0] = den;
	assign neg_s[0] = num[31];
	assign vld_s[0] = in_valid;
	assign tag_s[0] = tag_in;

	// One quotient bit per register stage.
	for (genvar g = 0; g < ST; g++) begin : g_stage
		logic [32:0] trial;
		logic [32:0] diff;
		always_comb begin
			trial = {rem_s[g], dvd_s[g][NW-1]};
			diff  = trial - {2'b00, den_s[g]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[g+1] <= dvd_s[g] << 1;
				den_s[g+1] <= den_s[g];
				neg_s[g+1] <= neg_s[g];
				tag_s[g+1] <= tag_s[g];
				if (!diff[32]) begin
					rem_s[g+1] <= diff[31:0];
					q_s[g+1]   <= {q_s[g][NW-2:0], 1'b1};
				end else begin
					rem_s[g+1] <= trial[31:0];
					q_s[g+1]   <= {q_s[g][NW-2:0], 1'b0};
				end
			end
		end
	end

	// Clamp magnitude to 2^31 and apply sign.
	always_comb begin
		logic [32:0] qc;
		qc = (q_s[ST] > NW'(33'h080000000)) ? 33'h080000000 : q_s[ST][32:0];
		if (neg_s[ST])
			quo = 32'(-qc);
		else
			quo = (qc[31]) ? 32'sh7FFFFFFF : qc[31:0];
	end

	assign out_valid = vld_s[ST];
	assign tag_out   = tag_s[ST];

endmodule

// ----- hw/rtl/wsp_clip.sv -----
// ----------------------------------------------------------------------------
// Clip row evaluator
// Three registered products, floor shift, sum and saturation for one row.
// ----------------------------------------------------------------------------
module wsp_clip
	import wsp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  wsp_in_t            pos,
	input  wsp_row_t           row,
	output logic signed [31:0] clip
);
	logic signed [63:0] px_s1, py_s1, pz_s1;
	logic signed [31:0] t_s1;
	logic signed [63:0] sum;
	logic signed [31:0] clip_s2;

	// Products, one multiplier each.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= 64'(pos.pos_x) * 64'(row.wx);
			py_s1 <= 64'(pos.pos_y) * 64'(row.wy);
			pz_s1 <= 64'(pos.pos_z) * 64'(row.wz);
			t_s1  <= row.wt;
		end
	end

	// Arithmetic shift is floor division by 2^FRAC_BITS.
	always_comb begin
		sum = (px_s1 >>> FRAC_BITS) + (py_s1 >>> FRAC_BITS)
			+ (pz_s1 >>> FRAC_BITS) + 64'(t_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clip_s2 <= sat32(sum);
		end
	end

	assign clip = clip_s2;

endmodule

// ----- hw/rtl/world_to_screen_projection_unit.sv -----
// ----------------------------------------------------------------------------
// World to screen projection unit
// Pipeline: clip products, clip sum, divider stages, scale products, result register.
// Throughput: one item per cycle while the skid register is empty; the divider stages set the latency.
// A stalled result moves into a skid register, so in_ready comes from a register.
// Reset clears valid bits; matrix resets to zero, screen to 1920 by 1080.
// ----------------------------------------------------------------------------
`include "world_to_screen_projection_unit_defines.svh"

module world_to_screen_projection_unit
	import wsp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  wsp_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output wsp_out_t              out_data
);
	localparam logic signed [31:0] W_THRESH = 32'((64'd1 << FRAC_BITS) / 100);
	localparam int TAG_W = 1 + SCR_W - 1;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] reg_q [6];
	logic [SCR_W-1:0]      scr_w_q, scr_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) reg_q[i] <= '0;
			scr_w_q <= SCR_W'(1920);
			scr_h_q <= SCR_W'(1080);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_SCR_W: scr_w_q <= cfg_data[SCR_W-1:0];
				REG_SCR_H: scr_h_q <= cfg_data[SCR_W-1:0];
				default:   reg_q[cfg_index] <= cfg_data;
			endcase
		end
	end

	function automatic wsp_row_t mk_row(input logic [63:0] xy, input logic [63:0] zt);
		wsp_row_t r;
		r.wx = xy[31:0];
		r.wy = xy[63:32];
		r.wz = zt[31:0];
		r.wt = zt[63:32];
		return r;
	endfunction

	// Global stall: the pipeline advances while the skid register is empty.
	logic en;
	logic skid_v_q;
	assign en       = !skid_v_q;
	assign in_ready = en;

	// Clip stage.
	logic signed [31:0] cx, cy, cw;
	logic               v_s1, v_s2;

	wsp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip_x (.clk, .en, .pos(in_data),
		.row(mk_row(reg_q[0], reg_q[1])), .clip(cx));
	wsp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip_y (.clk, .en, .pos(in_data),
		.row(mk_row(reg_q[2], reg_q[3])), .clip(cy));
	wsp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip_w (.clk, .en, .pos(in_data),
		.row(mk_row(reg_q[4], reg_q[5])), .clip(cw));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Visibility test and divisor.
	logic       vis;
	logic [30:0] den;
	assign vis = (cw >= W_THRESH) && (cw > 0);
	assign den = vis ? cw[30:0] : 31'd1;

	// Two dividers; each carries visibility and half the screen width (x) or height (y) in its tag.
	logic               dvx_v, dvy_v;
	logic signed [31:0] nx, ny;
	logic [TAG_W-1:0]   tag_x, tag_y;

	wsp_divider #(.FRAC_BITS(FRAC_BITS), .TAG_W(TAG_W)) u_div_x (
		.clk, .arst_n, .en, .in_valid(v_s2), .num(cx), .den,
		.tag_in({vis, scr_w_q[SCR_W-1:1]}), .out_valid(dvx_v), .quo(nx), .tag_out(tag_x));
	wsp_divider #(.FRAC_BITS(FRAC_BITS), .TAG_W(TAG_W)) u_div_y (
		.clk, .arst_n, .en, .in_valid(v_s2), .num(cy), .den,
		.tag_in({vis, scr_h_q[SCR_W-1:1]}), .out_valid(dvy_v), .quo(ny), .tag_out(tag_y));

	// Scale stage: products registered before centering.
	logic signed [63:0] px_s3, py_s3;
	logic [SCR_W-2:0]   hw_s3, hh_s3;
	logic               vis_s3, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= dvx_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hw_s3  <= tag_x[SCR_W-2:0];
			hh_s3  <= tag_y[SCR_W-2:0];
			vis_s3 <= tag_x[TAG_W-1];
			px_s3  <= 64'(nx) * $signed({51'd0, tag_x[SCR_W-2:0]});
			py_s3  <= 64'(ny) * $signed({51'd0, tag_y[SCR_W-2:0]});
		end
	end

	// Centering and result register.
	logic signed [63:0] sx, sy;
	always_comb begin
		sx = ($signed({51'd0, hw_s3}) <<< FRAC_BITS) + px_s3;
		sy = ($signed({51'd0, hh_s3}) <<< FRAC_BITS) - py_s3;
	end

	logic     res_v_s4;
	wsp_out_t res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s4 <= 1'b0;
		end else if (en) begin
			res_v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4.visible  <= vis_s3;
			res_s4.screen_x <= vis_s3 ? sat32(sx) : 32'sd0;
			res_s4.screen_y <= vis_s3 ? sat32(sy) : 32'sd0;
		end
	end

	// Skid register: holds a result that the receiver did not take, captured as
	// the pipeline advances, then freezes the pipeline until drained.
	wsp_out_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready)
				skid_v_q <= 1'b0;
		end else if (res_v_s4 && !out_ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && res_v_s4 && !out_ready) begin
			skid_q <= res_s4;
		end
	end

	assign out_valid = skid_v_q || res_v_s4;
	assign out_data  = skid_v_q ? skid_q : res_s4;

	// Both dividers run in lockstep.
	`WSP_ASSERT_IMPL(a_div_lockstep, clk, arst_n, 1'b1, dvx_v == dvy_v, "divider valids differ")
	// A hidden point always reports zero coordinates.
	`WSP_ASSERT_IMPL(a_hidden_zero, clk, arst_n, out_valid && !out_data.visible,
		out_data.screen_x == 0 && out_data.screen_y == 0, "hidden point not zero")
	// A stalled result holds.
	`WSP_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data), "stalled result changed")

endmodule

// ----- test/projection_checker.sv -----
// ----------------------------------------------------------------------------
// Projection unit checker
// Watches the configuration port and both item channels. It predicts the
// screen position of every accepted world point and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module projection_checker
	import wsp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  wsp_in_t               in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  wsp_out_t              out_data,
	output int                    errors,
	output int                    pending
);

	localparam int  FB        = FRAC_BITS_DEF;
	localparam longint W_MIN  = (64'd1 << FB) / 100;

	logic [63:0] matrix_regs [6];
	logic [13:0] scr_width;
	logic [13:0] scr_height;
	wsp_out_t    screen_queue [$];

	function automatic logic signed [31:0] clamp_s32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// One clip coordinate: floored products, exact sum, then clamp.
	function automatic longint clip_coord(input wsp_in_t p, input logic [63:0] wxy,
			input logic [63:0] wzt);
		longint sum;
		sum = ((longint'(p.pos_x) * longint'($signed(wxy[31:0]))) >>> FB)
			+ ((longint'(p.pos_y) * longint'($signed(wxy[63:32]))) >>> FB)
			+ ((longint'(p.pos_z) * longint'($signed(wzt[31:0]))) >>> FB)
			+ longint'($signed(wzt[63:32]));
		return longint'(clamp_s32(sum));
	endfunction

	// Division truncated toward zero, magnitude capped at 2^31.
	function automatic longint ndc_divide(input longint num, input longint w);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : num;
		q = (mag << FB) / w;
		if (q > 64'h80000000)
			q = 64'h80000000;
		return longint'(clamp_s32((num < 0) ? -longint'(q) : longint'(q)));
	endfunction

	function automatic wsp_out_t project_point(input wsp_in_t p);
		wsp_out_t r;
		longint cx, cy, cw, nx, ny, hw, hh;
		cx = clip_coord(p, matrix_regs[0], matrix_regs[1]);
		cy = clip_coord(p, matrix_regs[2], matrix_regs[3]);
		cw = clip_coord(p, matrix_regs[4], matrix_regs[5]);
		r = '0;
		if (cw < W_MIN || cw <= 0)
			return r;
		nx = ndc_divide(cx, cw);
		ny = ndc_divide(cy, cw);
		hw = longint'(scr_width >> 1);
		hh = longint'(scr_height >> 1);
		r.visible  = 1'b1;
		r.screen_x = clamp_s32(hw * (64'sd1 << FB) + nx * hw);
		r.screen_y = clamp_s32(hh * (64'sd1 << FB) - ny * hh);
		return r;
	endfunction

	// Track configuration, queue predictions, compare results.
	always @(posedge clk or negedge arst_n) begin
		wsp_out_t exp_item;
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				matrix_regs[i] = '0;
			scr_width  = 14'd1920;
			scr_height = 14'd1080;
			screen_queue.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index < 6)
					matrix_regs[cfg_index] = cfg_data;
				else if (cfg_idx_t'(cfg_index) == REG_SCR_W)
					scr_width = cfg_data[13:0];
				else
					scr_height = cfg_data[13:0];
			end
			if (out_valid && out_ready) begin
				if (screen_queue.size() == 0) begin
					$error("result item with nothing expected");
					errors++;
				end else begin
					exp_item = screen_queue.pop_front();
					if (out_data.visible !== exp_item.visible) begin
						$error("visible: expected %0d, got %0d", exp_item.visible,
							out_data.visible);
						errors++;
					end
					if (out_data.screen_x !== exp_item.screen_x) begin
						$error("screen_x: expected %0d, got %0d", exp_item.screen_x,
							out_data.screen_x);
						errors++;
					end
					if (out_data.screen_y !== exp_item.screen_y) begin
						$error("screen_y: expected %0d, got %0d", exp_item.screen_y,
							out_data.screen_y);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				screen_queue.push_back(project_point(in_data));
			pending = screen_queue.size();
		end
	end

endmodule

// ----- test/tb_world_to_screen_projection_unit.sv -----
// ----------------------------------------------------------------------------
// Projection unit testbench
// Drives world points through several matrix and screen settings, with
// random gaps and stalls on both channels; the checker judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_world_to_screen_projection_unit;
	import wsp_pkg::*;

	localparam int  ONE   = 65536;
	localparam int  DRAIN = 120;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	wsp_in_t               in_data;
	logic                  out_valid;
	logic                  out_ready;
	wsp_out_t              out_data;
	int                    errors;
	int                    pending;

	bit quiet;
	int hold_request;

	world_to_screen_projection_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	projection_checker checker_inst (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard limit on the run.
	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: random stalls, or one long hold-off when requested.
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold = hold_request;
				hold_request = 0;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || ($urandom_range(99) >= 9);
			end
		end
	end

	function automatic logic [63:0] pair(input int lo, input int hi);
		return {hi[31:0], lo[31:0]};
	endfunction

	// One register write; the enable stays high so writes can follow directly.
	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// Full register set; called only while the block is empty.
	task automatic load_setup(input logic [63:0] m [6], input int sw, input int sh);
		for (int i = 0; i < 6; i++)
			write_reg(cfg_idx_t'(i), m[i]);
		write_reg(REG_SCR_W, 64'(sw));
		write_reg(REG_SCR_H, 64'(sh));
		cfg_we <= 1'b0;
	endtask

	// Offer one item; returns at the falling edge after acceptance.
	task automatic send_point(input int px, input int py, input int pz);
		while (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{pos_x: px, pos_y: py, pos_z: pz};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	function automatic int small_coord();
		return $signed($urandom_range(32 * ONE)) - 16 * ONE;
	endfunction

	initial begin
		logic [63:0] m [6];
		int sw, sh, n;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		in_data      = '0;
		quiet        = 1'b0;
		hold_request = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset matrix: clip w is zero, nothing is visible.
		send_point(ONE, -ONE, 5 * ONE);
		send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		wait_drained();

		// Identity-like setup: x and y pass through, w equals z.
		m[0] = pair(ONE, 0); m[1] = pair(0, 0);
		m[2] = pair(0, ONE); m[3] = pair(0, 0);
		m[4] = pair(0, 0);   m[5] = pair(ONE, 0);
		load_setup(m, 1920, 1080);
		send_point(ONE, ONE, 655);              // w exactly at the threshold
		send_point(ONE, ONE, 654);              // just below the threshold
		send_point(0, 0, 0);                    // zero w
		send_point(ONE, ONE, -ONE);             // negative w
		send_point(32'h7FFFFFFF, 32'h80000000, 655);    // quotients saturate
		send_point(32'h80000000, 32'h7FFFFFFF, 655);
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_point(32'h80000000, 32'h80000000, 32'h80000000);
		send_point(-ONE, ONE / 2, 2 * ONE);
		send_point(0, 0, ONE);
		send_point(32'hFFFFFFFF, 1, 32'h7FFFFFFF);
		wait_drained();

		// Extreme weights: clip sums saturate; screen sizes at the edges.
		m[0] = pair(32'h7FFFFFFF, 32'h80000000); m[1] = pair(32'h7FFFFFFF, 32'h7FFFFFFF);
		m[2] = pair(32'h80000000, 32'h7FFFFFFF); m[3] = pair(32'h80000000, 32'h80000000);
		m[4] = pair(0, 0);                       m[5] = pair(0, 32'h7FFFFFFF);
		load_setup(m, 16383, 8192);
		send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		send_point(ONE, ONE, ONE);
		wait_drained();
		load_setup(m, 1, 0);
		send_point(ONE, -ONE, ONE);
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 0);
		wait_drained();

		// Random phases: mostly sane projections, some raw noise.
		for (int ph = 0; ph < 10; ph++) begin
			for (int r = 0; r < 6; r++)
				m[r] = {$urandom(), $urandom()};
			if (ph % 4 != 3) begin
				m[0] = pair(small_coord() / 8, small_coord() / 64);
				m[1] = pair(small_coord() / 64, small_coord());
				m[2] = pair(small_coord() / 64, small_coord() / 8);
				m[3] = pair(small_coord() / 64, small_coord());
				m[4] = pair(small_coord() / 64, small_coord() / 64);
				m[5] = pair($urandom_range(2 * ONE), $urandom_range(4 * ONE));
			end
			case (ph)
				0: begin sw = 0; sh = 1; end
				1: begin sw = 8192; sh = 8192; end
				2: begin sw = 16383; sh = 16383; end
				default: begin
					sw = $urandom_range(16383);
					sh = $urandom_range(16383);
				end
			endcase
			load_setup(m, sw, sh);
			quiet = (ph == 4);
			if (ph == 5)
				hold_request = 400;
			n = 113;
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(99) < 20)
					send_point($urandom(), $urandom(), $urandom());
				else
					send_point(small_coord(), small_coord(), small_coord());
			end
			wait_drained();
		end

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
